FILE: src/westwood_bandwidth_estimator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bandwidth estimator
// Concurrent checks on clk, disabled during rst; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WESTWOOD_BANDWIDTH_ESTIMATOR_CORE_MACROS_SVH
`define WESTWOOD_BANDWIDTH_ESTIMATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define WBE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbe assertion failed");
`define WBE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbe assertion failed");
`else
`define WBE_ASSERT_IMP(label, ante, cons)
`define WBE_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: src/wbe_pkg.sv
// ----------------------------------------------------------------------------
// Bandwidth estimator package
// Field widths, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
package wbe_pkg;

  localparam int TIME_BITS_DEFAULT  = 48;
  localparam int COUNT_BITS_DEFAULT = 48;

  localparam int ACK_BITS  = 24;
  localparam int NOW_BITS  = 48;
  localparam int SRTT_BITS = 32;
  localparam int OUT_BITS  = 48;
  localparam int CFG_BITS  = 32;
  localparam int ADDR_BITS = 3;

  localparam int IN_TDATA_BITS  = 104;
  localparam int OUT_TDATA_BITS = 48;

  // register select is byte address bit 2
  localparam int   REG_SEL_BIT    = 2;
  localparam logic REG_IDX_FLOOR  = 1'b0;
  localparam logic REG_IDX_TICKS  = 1'b1;

  localparam logic [CFG_BITS-1:0] TICKS_RESET = 32'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: src/wbe_divider.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// One quotient bit per cycle; done pulses when the last quotient bit is registered.
// ----------------------------------------------------------------------------
module wbe_divider #(
  parameter int WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output logic [WIDTH-1:0]    quotient,
  output logic [WIDTH-1:0]    remainder,
  output wbe_pkg::div_status_t status
);
  import wbe_pkg::*;

  `include "westwood_bandwidth_estimator_core_macros.svh"

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quot;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [CW-1:0]    count;
  logic             busy;
  logic             done;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem, quot[WIDTH-1]};
    ge      = shifted >= {1'b0, dsr};
    diff    = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[WIDTH-2:0], ge};
      rem  <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign quotient    = quot;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

  `WBE_ASSERT_NXT(a_start_busy, start, busy)
  `WBE_ASSERT_IMP(a_busy_count, busy, count != '0)
  `WBE_ASSERT_IMP(a_rem_below_divisor, done && (dsr != '0), rem < dsr)

endmodule

FILE: src/westwood_bandwidth_estimator_core.sv
// ----------------------------------------------------------------------------
// Westwood+ bandwidth estimator core
// Per-ack sample timing, rate division and two cascaded 7/8 filters.
// ----------------------------------------------------------------------------
// One ack event per input transfer; exactly one output transfer per event.
// Processing is sequential: s_axis_tready is high only when the core is idle.
// An event that closes a sample sends its time to the shared bit-serial divider,
// which is DW bits wide, where DW is the larger of TIME_BITS and COUNT_BITS.
// The divider first turns elapsed ticks into coarse units and then divides
// the sample bytes by that count. Other events skip the divider. The next
// input transfer can be taken in the cycle after the result is registered.
// The output register lets the next event enter while a result waits for
// m_axis_tready.
module westwood_bandwidth_estimator_core #(
  parameter int TIME_BITS  = wbe_pkg::TIME_BITS_DEFAULT,
  parameter int COUNT_BITS = wbe_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // ack_bytes[23:0], now_time[71:24], smoothed_rtt[103:72]
  input  logic [wbe_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bandwidth_estimate[47:0]
  output logic [wbe_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // sample_taken[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wbe_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [wbe_pkg::CFG_BITS-1:0]        pwdata,
  output logic [wbe_pkg::CFG_BITS-1:0]        prdata,
  output logic                                pready
);
  import wbe_pkg::*;

  `include "westwood_bandwidth_estimator_core_macros.svh"

  localparam int T  = TIME_BITS;
  localparam int C  = COUNT_BITS;
  localparam int DW = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_DIVA_GO   = 4'd2;
  localparam logic [3:0] S_DIVA_WAIT = 4'd3;
  localparam logic [3:0] S_ROUND     = 4'd4;
  localparam logic [3:0] S_DIVB_GO   = 4'd5;
  localparam logic [3:0] S_DIVB_WAIT = 4'd6;
  localparam logic [3:0] S_FILT1     = 4'd7;
  localparam logic [3:0] S_FILT2     = 4'd8;
  localparam logic [3:0] S_ADD       = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  // configuration
  logic [CFG_BITS-1:0] sample_floor_ticks;
  logic [CFG_BITS-1:0] ticks_per_unit;

  // estimator state
  logic         awaiting_first_ack;
  logic         awaiting_first_sample;
  logic [T-1:0] sample_start;
  logic [C-1:0] sample_bytes;
  logic [C-1:0] rate_less_smoothed;
  logic [C-1:0] rate_smoothed;

  // per-event working registers
  logic [3:0]           state;
  logic [ACK_BITS-1:0]  in_bytes;
  logic [T-1:0]         in_now;
  logic [SRTT_BITS-1:0] in_srtt;
  logic [T-1:0]         divisor_b;
  logic [C-1:0]         rate;
  logic                 taken;

  logic [OUT_BITS-1:0]  out_estimate;
  logic                 out_taken;
  logic                 out_valid;

  // shared divider
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [DW-1:0]        div_divisor;
  logic [DW-1:0]        div_quotient;
  logic [DW-1:0]        div_remainder;
  div_status_t          div_status;

  logic [T-1:0]         elapsed;
  logic [SRTT_BITS-1:0] min_period;
  logic                 close_sample;
  logic [CFG_BITS-1:0]  t_eff;
  logic [CFG_BITS:0]    twice_r;
  logic                 round_up;
  logic [T-1:0]         q_round;
  logic [C:0]           bytes_sum;
  logic                 cfg_write;
  logic                 in_xfer;
  logic                 out_free;

  function automatic logic [C-1:0] filter78(input logic [C-1:0] prev,
                                            input logic [C-1:0] x);
    logic [C-1:0] pq;
    logic [C-1:0] xq;
    logic [C-1:0] pq7;
    logic [5:0]   low;
    pq  = prev >> 3;
    xq  = x >> 3;
    pq7 = {prev[C-1:3], 3'b000} - pq;
    low = {prev[2:0], 3'b000} - {3'b000, prev[2:0]} + {3'b000, x[2:0]};
    return pq7 + xq + C'(low[5:3]);
  endfunction

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_floor_ticks <= '0;
      ticks_per_unit     <= TICKS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[REG_SEL_BIT])
        REG_IDX_FLOOR: sample_floor_ticks <= pwdata;
        REG_IDX_TICKS: ticks_per_unit     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_IDX_FLOOR: prdata = sample_floor_ticks;
      REG_IDX_TICKS: prdata = ticks_per_unit;
    endcase
  end

  // ------------------------------------------------------------------
  // datapath helpers
  // ------------------------------------------------------------------
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    elapsed      = in_now - sample_start;
    min_period   = (in_srtt > sample_floor_ticks) ? in_srtt : sample_floor_ticks;
    close_sample = (in_srtt != '0) && (elapsed > T'(min_period));
    t_eff        = (ticks_per_unit == '0) ? CFG_BITS'(1) : ticks_per_unit;
    // round half to even: compare twice the remainder against the divisor
    twice_r      = {div_remainder[CFG_BITS-1:0], 1'b0};
    round_up     = (twice_r > {1'b0, t_eff}) ||
                   ((twice_r == {1'b0, t_eff}) && div_quotient[0]);
    q_round      = div_quotient[T-1:0] + T'(round_up);
    bytes_sum    = {1'b0, sample_bytes} + (C+1)'(in_bytes);
  end

  assign div_start    = (state == S_DIVA_GO) || (state == S_DIVB_GO);
  assign div_dividend = (state == S_DIVB_GO) ? DW'(sample_bytes) : DW'(elapsed);
  assign div_divisor  = (state == S_DIVB_GO) ? DW'(divisor_b) : DW'(t_eff);

  wbe_divider #(
    .WIDTH(DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .status    (div_status)
  );

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      awaiting_first_ack    <= 1'b1;
      awaiting_first_sample <= 1'b1;
      sample_start          <= '0;
      sample_bytes          <= '0;
      rate_less_smoothed    <= '0;
      rate_smoothed         <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (awaiting_first_ack) begin
            awaiting_first_ack <= 1'b0;
            sample_start       <= in_now;
            state              <= S_ADD;
          end else if (close_sample) begin
            state <= S_DIVA_GO;
          end else begin
            state <= S_ADD;
          end
        end
        S_DIVA_GO:   state <= S_DIVA_WAIT;
        S_DIVA_WAIT: begin
          if (div_status.done) begin
            state <= S_ROUND;
          end
        end
        S_ROUND:     state <= S_DIVB_GO;
        S_DIVB_GO:   state <= S_DIVB_WAIT;
        S_DIVB_WAIT: begin
          if (div_status.done) begin
            state <= S_FILT1;
          end
        end
        S_FILT1: begin
          rate_less_smoothed <= awaiting_first_sample ? rate
                                                      : filter78(rate_less_smoothed, rate);
          state <= S_FILT2;
        end
        S_FILT2: begin
          rate_smoothed <= awaiting_first_sample ? rate
                                                 : filter78(rate_smoothed, rate_less_smoothed);
          awaiting_first_sample <= 1'b0;
          sample_bytes          <= '0;
          sample_start          <= in_now;
          state                 <= S_ADD;
        end
        S_ADD: begin
          // saturate the open sample's byte count
          sample_bytes <= bytes_sum[C] ? {C{1'b1}} : bytes_sum[C-1:0];
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_bytes <= s_axis_tdata[ACK_BITS-1:0];
      in_now   <= T'(s_axis_tdata[ACK_BITS+NOW_BITS-1:ACK_BITS]);
      in_srtt  <= s_axis_tdata[ACK_BITS+NOW_BITS+SRTT_BITS-1:ACK_BITS+NOW_BITS];
      taken    <= 1'b0;
    end else if (state == S_FILT2) begin
      taken <= 1'b1;
    end
    if (state == S_ROUND) begin
      divisor_b <= (q_round == '0) ? T'(1) : q_round;
    end
    if (state == S_DIVB_WAIT && div_status.done) begin
      rate <= div_quotient[C-1:0];
    end
    if (state == S_OUT && out_free) begin
      out_estimate <= OUT_BITS'(rate_smoothed);
      out_taken    <= taken;
    end
  end

  assign m_axis_tdata  = out_estimate;
  assign m_axis_tuser  = out_taken;
  assign m_axis_tvalid = out_valid;

  `WBE_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !s_axis_tready)
  `WBE_ASSERT_IMP(a_taken_after_seed, m_axis_tvalid && m_axis_tuser, !awaiting_first_sample)
  `WBE_ASSERT_IMP(a_rate_divisor_nonzero, state == S_DIVB_GO, divisor_b != '0)
  `WBE_ASSERT_IMP(a_div_idle_at_entry, state == S_DIVA_GO || state == S_DIVB_GO, !div_status.busy)

endmodule

FILE: sim/tb_westwood_bandwidth_estimator_core.sv
// ----------------------------------------------------------------------------
// Testbench for the Westwood+ bandwidth estimator core
// Drives ack events over the input stream and configuration over APB, keeps
// its own copy of the estimator state and checks every output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_westwood_bandwidth_estimator_core;
  import wbe_pkg::*;

  localparam logic [63:0] TIME_MASK   = (64'd1 << TIME_BITS_DEFAULT) - 64'd1;
  localparam logic [63:0] COUNT_MASK  = (64'd1 << COUNT_BITS_DEFAULT) - 64'd1;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          END_SETTLE  = 256;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 156;

  typedef struct packed {
    logic [OUT_BITS-1:0] bandwidth_estimate;
    logic                sample_taken;
  } est_entry_t;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                reg_idx;
    logic [CFG_BITS-1:0] value;
    logic [ACK_BITS-1:0] ack;
    logic [NOW_BITS-1:0] now;
    logic [SRTT_BITS-1:0] srtt;
    bit                  typed;
    est_entry_t          typed_exp;
  } table_row_t;

  logic                      clk;
  logic                      rst;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_BITS-1:0]      paddr;
  logic [CFG_BITS-1:0]       pwdata;
  logic [CFG_BITS-1:0]       prdata;
  logic                      pready;

  westwood_bandwidth_estimator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // estimator state as the testbench sees it
  logic [63:0] floor_ticks;
  logic [63:0] unit_ticks;
  bit          first_ack_pending;
  bit          first_sample_pending;
  logic [63:0] win_start;
  logic [63:0] win_bytes;
  logic [63:0] rate_fast;
  logic [63:0] rate_slow;

  est_entry_t  pending_estimates[$];
  int          mismatches;
  int          src_gap_pct;
  int          sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit stall_now(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // elapsed ticks to coarse units, half to even, never below one
  function automatic logic [63:0] ticks_to_units(input logic [63:0] elapsed,
                                                 input logic [63:0] t);
    logic [63:0] q;
    logic [63:0] r;
    if (t == 64'd0) t = 64'd1;
    q = elapsed / t;
    r = elapsed % t;
    if (r > t - r || (r == t - r && q[0])) q = q + 64'd1;
    if (q == 64'd0) q = 64'd1;
    return q;
  endfunction

  // operands stay below 2^48, so the sum cannot overflow
  function automatic logic [63:0] smooth_7_8(input logic [63:0] prev,
                                             input logic [63:0] x);
    return (64'd7 * prev + x) >> 3;
  endfunction

  task automatic estimate_bandwidth(input logic [ACK_BITS-1:0] ack,
                                    input logic [NOW_BITS-1:0] now,
                                    input logic [SRTT_BITS-1:0] srtt,
                                    output est_entry_t res);
    logic [63:0] now64;
    logic [63:0] elapsed;
    logic [63:0] gate;
    logic [63:0] rate;
    now64 = {16'd0, now} & TIME_MASK;
    res.sample_taken = 1'b0;
    if (first_ack_pending) begin
      first_ack_pending = 1'b0;
      win_start = now64;
    end else if (srtt != '0) begin
      elapsed = (now64 - win_start) & TIME_MASK;
      gate = (64'(srtt) > floor_ticks) ? 64'(srtt) : floor_ticks;
      if (elapsed > gate) begin
        rate = (win_bytes / ticks_to_units(elapsed, unit_ticks)) & COUNT_MASK;
        if (first_sample_pending) begin
          first_sample_pending = 1'b0;
          rate_fast = rate;
          rate_slow = rate;
        end else begin
          rate_fast = smooth_7_8(rate_fast, rate) & COUNT_MASK;
          rate_slow = smooth_7_8(rate_slow, rate_fast) & COUNT_MASK;
        end
        win_bytes = 64'd0;
        win_start = now64;
        res.sample_taken = 1'b1;
      end
    end
    if (win_bytes > COUNT_MASK - 64'(ack)) win_bytes = COUNT_MASK;
    else win_bytes = win_bytes + 64'(ack);
    res.bandwidth_estimate = rate_slow[OUT_BITS-1:0];
  endtask

  // entered and left at a falling edge; tvalid stays high after the transfer
  task automatic send_event(input logic [IN_TDATA_BITS-1:0] d, input bit typed,
                            input est_entry_t typed_exp);
    est_entry_t predicted;
    while (stall_now(src_gap_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    estimate_bandwidth(d[23:0], d[71:24], d[103:72], predicted);
    pending_estimates.push_back(typed ? typed_exp : predicted);
    @(negedge clk);
  endtask

  // drop tvalid and hold until every expected result has arrived
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_estimates.size() != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [ADDR_BITS-1:0] addr,
                          input logic [CFG_BITS-1:0] wdata,
                          output logic [CFG_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [CFG_BITS-1:0] value);
    logic [ADDR_BITS-1:0] addr;
    logic [CFG_BITS-1:0]  rd;
    addr = ADDR_BITS'(idx) << REG_SEL_BIT;
    apb_xfer(1'b1, addr, value, rd);
    if (idx == REG_IDX_FLOOR) floor_ticks = 64'(value);
    else unit_ticks = 64'(value);
    apb_xfer(1'b0, addr, '0, rd);
    if (rd !== value) begin
      $error("register %0d readback: expected %0h, actual %0h", idx, value, rd);
      mismatches++;
    end
  endtask

  function automatic table_row_t ack_row(input logic [ACK_BITS-1:0] ack,
                                         input logic [NOW_BITS-1:0] now,
                                         input logic [SRTT_BITS-1:0] srtt);
    table_row_t r;
    r.kind = ROW_EVENT;
    r.reg_idx = REG_IDX_FLOOR;
    r.value = '0;
    r.ack = ack;
    r.now = now;
    r.srtt = srtt;
    r.typed = 1'b0;
    r.typed_exp = '0;
    return r;
  endfunction

  // estimate still zero and no sample closed
  function automatic table_row_t zero_row(input logic [ACK_BITS-1:0] ack,
                                          input logic [NOW_BITS-1:0] now,
                                          input logic [SRTT_BITS-1:0] srtt);
    table_row_t r;
    r = ack_row(ack, now, srtt);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic table_row_t cfg_row(input logic idx, input logic [CFG_BITS-1:0] value);
    table_row_t r;
    r = ack_row('0, '0, '0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  initial begin : result_check
    est_entry_t want;
    bit         stall;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_estimates.size() == 0) begin
          $error("unexpected result: bandwidth_estimate %0d sample_taken %0b",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = pending_estimates.pop_front();
          if (m_axis_tdata !== want.bandwidth_estimate) begin
            $error("bandwidth_estimate: expected %0d, actual %0d",
                   want.bandwidth_estimate, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.sample_taken) begin
            $error("sample_taken: expected %0b, actual %0b", want.sample_taken, m_axis_tuser);
            mismatches++;
          end
        end
      end
      stall = stall_now(sink_stall_pct);
      @(negedge clk);
      m_axis_tready <= !stall;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    table_row_t          rows[$];
    logic [ACK_BITS-1:0] ack;
    logic [SRTT_BITS-1:0] srtt;
    logic [CFG_BITS-1:0] new_floor;
    logic [CFG_BITS-1:0] new_ticks;
    logic [63:0]         cur_now;
    logic [63:0]         gate;
    logic [63:0]         delta;
    int                  pick;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    floor_ticks = 64'd0;
    unit_ticks = 64'(TICKS_RESET);
    first_ack_pending = 1'b1;
    first_sample_pending = 1'b1;
    win_start = 64'd0;
    win_bytes = 64'd0;
    rate_fast = 64'd0;
    rate_slow = 64'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first ack only marks the start; unknown RTT and a short window close nothing
    rows.push_back(zero_row(24'hFF_FFFF, 48'd0, 32'd0));
    rows.push_back(zero_row(24'd0, 48'd2000, 32'd0));
    rows.push_back(zero_row(24'd1, 48'd2000, 32'hFFFF_FFFF));
    // first sample seeds both filters
    rows.push_back(ack_row(24'd1000, 48'd3000, 32'd1));
    // rounding ties: down to zero then clamped, up from odd, held at even
    rows.push_back(ack_row(24'd0, 48'd3500, 32'd499));
    rows.push_back(ack_row(24'd500, 48'd5000, 32'd1));
    rows.push_back(ack_row(24'hFF_FFFF, 48'd7500, 32'd1));
    // time going backwards, then top of range and wrap
    rows.push_back(ack_row(24'd7, 48'd100, 32'd1));
    rows.push_back(ack_row(24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd1));
    rows.push_back(ack_row(24'd0, 48'd5, 32'd1));
    // zero divisor register acts as one
    rows.push_back(cfg_row(REG_IDX_TICKS, 32'd0));
    rows.push_back(ack_row(24'd1234, 48'd9, 32'd3));
    rows.push_back(ack_row(24'd0, 48'd20, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_IDX_TICKS, 32'hFFFF_FFFF));
    rows.push_back(ack_row(24'hFF_FFFF, 48'h8000_0000_0000, 32'hFFFF_FFFF));
    // floor dominates a tiny RTT
    rows.push_back(cfg_row(REG_IDX_FLOOR, 32'hFFFF_FFFF));
    rows.push_back(ack_row(24'h80_0000, 48'h8000_FFFF_FFFE, 32'd1));
    rows.push_back(ack_row(24'h00_0001, 48'h8001_0000_0000, 32'd1));
    rows.push_back(cfg_row(REG_IDX_FLOOR, 32'd0));
    rows.push_back(cfg_row(REG_IDX_TICKS, 32'd1));
    rows.push_back(ack_row(24'hFF_FFFF, 48'h8001_0000_0002, 32'd1));
    rows.push_back(ack_row(24'hFF_FFFF, 48'h8001_0000_0010, 32'd0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_for_results();
        set_register(rows[i].reg_idx, rows[i].value);
      end else begin
        send_event({rows[i].srtt, rows[i].now, rows[i].ack}, rows[i].typed,
                   rows[i].typed_exp);
      end
    end

    cur_now = 64'h8001_0000_0010;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_results();
      case (ph % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 72; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 72; end
        default: begin src_gap_pct = 23; sink_stall_pct = 23; end
      endcase
      case (ph)
        0: begin new_floor = 32'd0;         new_ticks = 32'd1;         end
        1: begin new_floor = 32'hFFFF_FFFF; new_ticks = 32'hFFFF_FFFF; end
        2: begin new_floor = 32'd0;         new_ticks = 32'd0;         end
        default: begin
          case ($urandom_range(2))
            0: new_floor = 32'd0;
            1: new_floor = $urandom_range(5000);
            default: new_floor = $urandom;
          endcase
          case ($urandom_range(3))
            0: new_ticks = TICKS_RESET;
            1: new_ticks = $urandom_range(1, 100);
            2: new_ticks = $urandom;
            default: new_ticks = 32'd1;
          endcase
        end
      endcase
      set_register(REG_IDX_FLOOR, new_floor);
      set_register(REG_IDX_TICKS, new_ticks);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ack = ACK_BITS'($urandom);
        if ($urandom_range(9) == 0) ack = $urandom_range(1) ? '1 : '0;
        pick = $urandom_range(99);
        if (pick < 8) srtt = '0;
        else if (pick < 13) srtt = '1;
        else srtt = $urandom >> $urandom_range(31);
        if (pick >= 8 && srtt == '0) srtt = 32'd1;
        gate = (64'(srtt) > floor_ticks) ? 64'(srtt) : floor_ticks;
        pick = $urandom_range(99);
        // mostly windows that close, some that stay open, some noise in time
        if (pick < 60) delta = gate + 64'd1 + rand64() % (gate + 64'd1);
        else if (pick < 85) delta = rand64() % (gate + 64'd1);
        else if (pick < 95) delta = 64'd0;
        else begin
          cur_now = rand64();
          delta = 64'd0;
        end
        cur_now = (cur_now + delta) & TIME_MASK;
        send_event({srtt, cur_now[NOW_BITS-1:0], ack}, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
